// ===== sv/ptaa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptaa_pkg
// Shared widths, register indexes, reset values and scale constants of the
// period-measuring tachometer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptaa_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_PPR     = 3'd0;
  localparam logic [2:0] REG_TIMEOUT = 3'd1;
  localparam logic [2:0] REG_MARGIN  = 3'd2;
  localparam logic [2:0] REG_SLOW    = 3'd3;
  localparam logic [2:0] REG_FAST    = 3'd4;
  localparam logic [2:0] REG_MAXRD   = 3'd5;

  // register reset values
  localparam logic [7:0]  PPR_RST     = 8'd2;
  localparam logic [31:0] TIMEOUT_RST = 32'd10000000;
  localparam logic [15:0] MARGIN_RST  = 16'd2000;
  localparam logic [31:0] SLOW_RST    = 32'd40000;
  localparam logic [31:0] FAST_RST    = 32'd5000;
  localparam logic [3:0]  MAXRD_RST   = 4'd10;

  // state reset value of the period registers
  localparam logic [31:0] PERIOD_RST  = 32'd10001000;

  // serial divider geometry: 38-bit dividend, 33-bit divisor
  localparam int unsigned DIV_NW    = 38;
  localparam int unsigned DIV_DW    = 33;
  localparam logic [5:0]  DIV_STEPS = 6'd38;

  // frequency scale and unit constants
  localparam logic [37:0] FREQ_NUM  = 38'd10000000000;
  localparam logic [32:0] HZ_DIV    = 33'd10000;
  localparam logic [5:0]  RPM_MUL   = 6'd60;

  // request kinds
  localparam logic REQ_PULSE   = 1'b0;
  localparam logic REQ_READOUT = 1'b1;

endpackage

`default_nettype wire

// ===== sv/pulse_tachometer_adaptive_average.sv =====
// ----------------------------------------------------------------------------
// pulse_tachometer_adaptive_average
// A pulse transaction is handled in idle, or takes one divider pass when an
//   averaging window closes and two when the count remap also divides.
// A readout raises out_tvalid after five divider passes and the HZS, SMS and
//   OUT steps, once the output register is free; four passes when
//   the timeout forces zero or the average period is zero.
// One transaction at a time (in_tready only in idle); shared divider, one
//   quotient bit per cycle. A finished readout waits in the output register.
// Reset: synchronous, active low; control registers and history return to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_tachometer_adaptive_average #(
  parameter int SMOOTH_DEPTH = 1            // rpm history length, 1..16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,       // [31:0] time_us
  input  wire logic         in_tuser,       // [0] req_type
  // result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [143:0]      out_tdata,      // [31:0] freq_scaled, [50:32] freq_hz,
                                            // [75:51] rpm, [100:76] rpm_smoothed,
                                            // [132:101] last_period_us,
                                            // [136:133] readings_in_use, rest zero
  // configuration
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int SW = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_P_AVG = 4'd1;   // window average division
  localparam logic [3:0] ST_P_MAP = 4'd2;   // count remap division
  localparam logic [3:0] ST_R_FRQ = 4'd3;   // 1e10 / average period
  localparam logic [3:0] ST_R_HZS = 4'd4;
  localparam logic [3:0] ST_R_HZ  = 4'd5;   // freq / 10000
  localparam logic [3:0] ST_R_PPR = 4'd6;   // freq / pulses per rev
  localparam logic [3:0] ST_R_RPM = 4'd7;   // (x * 60) / 10000
  localparam logic [3:0] ST_R_SMS = 4'd8;
  localparam logic [3:0] ST_R_SMO = 4'd9;   // history total / depth
  localparam logic [3:0] ST_R_OUT = 4'd10;

  logic [3:0]  state_r, state_nxt;

  // configuration registers
  logic [7:0]  ppr_r, ppr_nxt;
  logic [31:0] tmo_r, tmo_nxt;
  logic [15:0] margin_r, margin_nxt;
  logic [31:0] slow_r, slow_nxt;
  logic [31:0] fast_r, fast_nxt;
  logic [3:0]  maxrd_r, maxrd_nxt;

  // measurement state
  logic [31:0] last_r, last_nxt;
  logic [31:0] period_r, period_nxt;
  logic [31:0] avg_r, avg_nxt;
  logic [35:0] acc_r, acc_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        hold_r, hold_nxt;

  // rpm history
  logic [24:0]   hist_r [SMOOTH_DEPTH];
  logic [SW-1:0] slot_r, slot_nxt;
  logic [28:0]   total_r, total_nxt;
  logic          hist_we;

  // readout scratch
  logic [31:0] freq_r, freq_nxt;
  logic [18:0] hz_r, hz_nxt;
  logic [24:0] rpm_r, rpm_nxt;
  logic [24:0] smo_r, smo_nxt;

  // output register
  logic         out_valid_r, out_valid_nxt;
  logic [143:0] out_data_r, out_data_nxt;

  // bit-serial restoring divider
  logic [ptaa_pkg::DIV_NW-1:0] div_q_r, div_q_nxt;
  logic [ptaa_pkg::DIV_DW-1:0] div_rem_r, div_rem_nxt;
  logic [ptaa_pkg::DIV_DW-1:0] div_d_r, div_d_nxt;
  logic [5:0]                  div_cnt_r, div_cnt_nxt;
  logic                        div_start;
  logic [ptaa_pkg::DIV_NW-1:0] div_a;
  logic [ptaa_pkg::DIV_DW-1:0] div_b;
  logic [ptaa_pkg::DIV_DW:0]   div_shift, div_diff;
  logic                        div_ge, div_done;

  // combinational helpers
  logic        in_fire;
  logic [31:0] t_in, since, thr, margin_ext;
  logic        is_zero;
  logic [3:0]  hi, hm1;
  logic [33:0] a_s, den_s;
  logic [32:0] a_abs, den_abs;
  logic [36:0] num_abs;
  logic [37:0] rpm_prod;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign t_in       = in_tdata;

  // divider datapath: one quotient bit per cycle
  assign div_shift = {div_rem_r, div_q_r[ptaa_pkg::DIV_NW-1]};
  assign div_ge    = (div_shift >= {1'b0, div_d_r});
  assign div_diff  = div_shift - {1'b0, div_d_r};
  assign div_done  = (div_cnt_r == 6'd0);

  // timeout and remap helpers
  assign since      = (t_in < last_r) ? 32'd0 : (t_in - last_r);
  assign margin_ext = {16'd0, margin_r};
  always_comb begin
    if (hold_r) begin
      thr = (margin_ext > tmo_r) ? 32'd0 : (tmo_r - margin_ext);
    end else begin
      thr = tmo_r;
    end
  end
  assign is_zero = (period_r > thr) || (since > thr);

  assign hi      = (maxrd_r == 4'd0) ? 4'd1 : maxrd_r;
  assign hm1     = hi - 4'd1;
  assign a_s     = {2'b00, period_r} - {2'b00, slow_r};
  assign den_s   = {2'b00, fast_r} - {2'b00, slow_r};
  assign a_abs   = a_s[33] ? 33'(-a_s) : a_s[32:0];
  assign den_abs = den_s[33] ? 33'(-den_s) : den_s[32:0];
  assign num_abs = a_abs * hm1;
  assign rpm_prod = div_q_r[31:0] * ptaa_pkg::RPM_MUL;

  always_comb begin
    state_nxt     = state_r;
    ppr_nxt       = ppr_r;
    tmo_nxt       = tmo_r;
    margin_nxt    = margin_r;
    slow_nxt      = slow_r;
    fast_nxt      = fast_r;
    maxrd_nxt     = maxrd_r;
    last_nxt      = last_r;
    period_nxt    = period_r;
    avg_nxt       = avg_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    slot_nxt      = slot_r;
    total_nxt     = total_r;
    hist_we       = 1'b0;
    freq_nxt      = freq_r;
    hz_nxt        = hz_r;
    rpm_nxt       = rpm_r;
    smo_nxt       = smo_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_a         = '0;
    div_b         = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      unique case (cfg_addr)
        ptaa_pkg::REG_PPR:     ppr_nxt    = cfg_wdata[7:0];
        ptaa_pkg::REG_TIMEOUT: tmo_nxt    = cfg_wdata;
        ptaa_pkg::REG_MARGIN:  margin_nxt = cfg_wdata[15:0];
        ptaa_pkg::REG_SLOW:    slow_nxt   = cfg_wdata;
        ptaa_pkg::REG_FAST:    fast_nxt   = cfg_wdata;
        ptaa_pkg::REG_MAXRD:   maxrd_nxt  = cfg_wdata[3:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == ptaa_pkg::REQ_PULSE) begin
            period_nxt = t_in - last_r;
            last_nxt   = t_in;
            if (idx_r >= cnt_r) begin
              // window closed: average the old window
              div_start = 1'b1;
              div_a     = {2'b00, acc_r};
              div_b     = {29'd0, ((cnt_r == 4'd0) ? 4'd1 : cnt_r)};
              state_nxt = ST_P_AVG;
            end else begin
              idx_nxt = idx_r + 4'd1;
              acc_nxt = acc_r + {4'd0, period_nxt};
            end
          end else begin
            hold_nxt = is_zero;
            if (is_zero) begin
              freq_nxt  = 32'd0;
              state_nxt = ST_R_HZS;
            end else if (avg_r == 32'd0) begin
              freq_nxt  = '1;
              state_nxt = ST_R_HZS;
            end else begin
              div_start = 1'b1;
              div_a     = ptaa_pkg::FREQ_NUM;
              div_b     = {1'b0, avg_r};
              state_nxt = ST_R_FRQ;
            end
          end
        end
      end
      ST_P_AVG: begin
        if (div_done) begin
          avg_nxt   = div_q_r[31:0];
          acc_nxt   = {4'd0, period_r};
          idx_nxt   = 4'd1;
          state_nxt = ST_IDLE;
          if (den_s == 34'd0) begin
            cnt_nxt = (period_r <= fast_r) ? hi : 4'd1;
          end else if ((a_s == 34'd0) || (hm1 == 4'd0) || (a_s[33] != den_s[33])) begin
            // quotient is zero or negative: count clamps to one
            cnt_nxt = 4'd1;
          end else begin
            div_start = 1'b1;
            div_a     = {1'b0, num_abs};
            div_b     = den_abs;
            state_nxt = ST_P_MAP;
          end
        end
      end
      ST_P_MAP: begin
        if (div_done) begin
          if (div_q_r >= {34'd0, hm1}) begin
            cnt_nxt = hi;
          end else begin
            cnt_nxt = div_q_r[3:0] + 4'd1;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_R_FRQ: begin
        if (div_done) begin
          freq_nxt  = (div_q_r[37:32] != 6'd0) ? 32'hFFFF_FFFF : div_q_r[31:0];
          state_nxt = ST_R_HZS;
        end
      end
      ST_R_HZS: begin
        div_start = 1'b1;
        div_a     = {6'd0, freq_r};
        div_b     = ptaa_pkg::HZ_DIV;
        state_nxt = ST_R_HZ;
      end
      ST_R_HZ: begin
        if (div_done) begin
          hz_nxt    = div_q_r[18:0];
          div_start = 1'b1;
          div_a     = {6'd0, freq_r};
          div_b     = {25'd0, ((ppr_r == 8'd0) ? 8'd1 : ppr_r)};
          state_nxt = ST_R_PPR;
        end
      end
      ST_R_PPR: begin
        if (div_done) begin
          div_start = 1'b1;
          div_a     = rpm_prod;
          div_b     = ptaa_pkg::HZ_DIV;
          state_nxt = ST_R_RPM;
        end
      end
      ST_R_RPM: begin
        if (div_done) begin
          rpm_nxt   = div_q_r[24:0];
          total_nxt = total_r - {4'd0, hist_r[slot_r]} + {4'd0, div_q_r[24:0]};
          hist_we   = 1'b1;
          slot_nxt  = (slot_r == SW'(SMOOTH_DEPTH - 1)) ? '0 : slot_r + SW'(1);
          state_nxt = ST_R_SMS;
        end
      end
      ST_R_SMS: begin
        div_start = 1'b1;
        div_a     = {9'd0, total_r};
        div_b     = 33'(SMOOTH_DEPTH);
        state_nxt = ST_R_SMO;
      end
      ST_R_SMO: begin
        if (div_done) begin
          smo_nxt   = div_q_r[24:0];
          state_nxt = ST_R_OUT;
        end
      end
      ST_R_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'd0, cnt_r, period_r, smo_r, rpm_r, hz_r, freq_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // divider sequencing
    if (div_start) begin
      div_q_nxt   = div_a;
      div_rem_nxt = '0;
      div_d_nxt   = div_b;
      div_cnt_nxt = ptaa_pkg::DIV_STEPS;
    end else if (!div_done) begin
      div_q_nxt   = {div_q_r[ptaa_pkg::DIV_NW-2:0], div_ge};
      div_rem_nxt = div_ge ? div_diff[ptaa_pkg::DIV_DW-1:0]
                           : div_shift[ptaa_pkg::DIV_DW-1:0];
      div_d_nxt   = div_d_r;
      div_cnt_nxt = div_cnt_r - 6'd1;
    end else begin
      div_q_nxt   = div_q_r;
      div_rem_nxt = div_rem_r;
      div_d_nxt   = div_d_r;
      div_cnt_nxt = div_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ppr_r       <= ptaa_pkg::PPR_RST;
      tmo_r       <= ptaa_pkg::TIMEOUT_RST;
      margin_r    <= ptaa_pkg::MARGIN_RST;
      slow_r      <= ptaa_pkg::SLOW_RST;
      fast_r      <= ptaa_pkg::FAST_RST;
      maxrd_r     <= ptaa_pkg::MAXRD_RST;
      last_r      <= '0;
      period_r    <= ptaa_pkg::PERIOD_RST;
      avg_r       <= ptaa_pkg::PERIOD_RST;
      acc_r       <= '0;
      idx_r       <= 4'd1;
      cnt_r       <= 4'd1;
      hold_r      <= 1'b0;
      slot_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      ppr_r       <= ppr_nxt;
      tmo_r       <= tmo_nxt;
      margin_r    <= margin_nxt;
      slow_r      <= slow_nxt;
      fast_r      <= fast_nxt;
      maxrd_r     <= maxrd_nxt;
      last_r      <= last_nxt;
      period_r    <= period_nxt;
      avg_r       <= avg_nxt;
      acc_r       <= acc_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      hold_r      <= hold_nxt;
      slot_r      <= slot_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      div_cnt_r   <= div_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    freq_r     <= freq_nxt;
    hz_r       <= hz_nxt;
    rpm_r      <= rpm_nxt;
    smo_r      <= smo_nxt;
    out_data_r <= out_data_nxt;
    div_q_r    <= div_q_nxt;
    div_rem_r  <= div_rem_nxt;
    div_d_r    <= div_d_nxt;
  end

  // rpm history, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SMOOTH_DEPTH; i++) begin
        hist_r[i] <= '0;
      end
    end else if (hist_we) begin
      hist_r[slot_r] <= rpm_nxt;
    end
  end

  // checks
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    div_cnt_r <= ptaa_pkg::DIV_STEPS)
    else $error("divider step count out of range");

  a_idx_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (idx_r != 4'd0) && (cnt_r != 4'd0) && (idx_r <= cnt_r))
    else $error("pulse index outside averaging window");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_R_OUT)
    else $error("result raised outside output state");

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    $past(div_start) |-> !div_done)
    else $error("divider finished on its start cycle");

endmodule

`default_nettype wire

// ===== tb/tb_pulse_tachometer_adaptive_average.sv =====
// ----------------------------------------------------------------------------
// tb_pulse_tachometer_adaptive_average
// Self-checking bench for the period-measuring tachometer: pulse and readout
// transactions are streamed in with random gaps, and every readout result is
// compared field by field against a cycle-free model of the averaging,
// timeout and rpm arithmetic. Several register settings are exercised,
// including extremes and the degenerate zero and equal-period cases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pulse_tachometer_adaptive_average;

  localparam int SMOOTH_DEPTH = 1;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 300;   // longer than a readout pass
  localparam int PHASE_ITEMS = 185;

  // Expected-result tracker: holds its own copy of registers and state and
  // queues one packed result per readout transaction.
  class tach_scoreboard;
    bit [7:0]  ppr;
    bit [31:0] timeout_us;
    bit [15:0] margin_us;
    bit [31:0] slow_us, fast_us;
    bit [3:0]  max_rd;
    bit [31:0] last_t, period, avg_period;
    longint unsigned acc;
    int unsigned win_idx, win_len;
    bit zero_hold;
    int unsigned rpm_hist[SMOOTH_DEPTH];
    int unsigned slot, hist_total;
    bit [143:0] readouts[$];
    int errors;

    function new();
      ppr = ptaa_pkg::PPR_RST; timeout_us = ptaa_pkg::TIMEOUT_RST;
      margin_us = ptaa_pkg::MARGIN_RST;
      slow_us = ptaa_pkg::SLOW_RST; fast_us = ptaa_pkg::FAST_RST;
      max_rd = ptaa_pkg::MAXRD_RST;
      last_t = 0; period = ptaa_pkg::PERIOD_RST; avg_period = ptaa_pkg::PERIOD_RST;
      acc = 0;
      win_idx = 1; win_len = 1; zero_hold = 0; slot = 0; hist_total = 0;
      foreach (rpm_hist[i]) rpm_hist[i] = 0;
      errors = 0;
    endfunction

    function void write_reg(bit [2:0] addr, bit [31:0] val);
      case (addr)
        ptaa_pkg::REG_PPR:     ppr = val[7:0];
        ptaa_pkg::REG_TIMEOUT: timeout_us = val;
        ptaa_pkg::REG_MARGIN:  margin_us = val[15:0];
        ptaa_pkg::REG_SLOW:    slow_us = val;
        ptaa_pkg::REG_FAST:    fast_us = val;
        ptaa_pkg::REG_MAXRD:   max_rd = val[3:0];
        default: ;
      endcase
    endfunction

    // linear count map, slow -> 1, fast -> max, truncating toward zero
    function int unsigned window_count(bit [31:0] p);
      longint hi, den, num, r;
      hi = (max_rd == 0) ? 1 : longint'(max_rd);
      den = longint'(fast_us) - longint'(slow_us);
      if (den == 0) begin
        r = (p <= fast_us) ? hi : 1;
      end else begin
        num = (longint'(p) - longint'(slow_us)) * (hi - 1);
        r = num / den + 1;
      end
      if (r < 1) r = 1;
      if (r > hi) r = hi;
      return int'(r);
    endfunction

    function void note_input(bit req, bit [31:0] t);
      bit [31:0] since, thr, freq;
      longint unsigned q, rpm, pp;
      if (req == ptaa_pkg::REQ_PULSE) begin
        period = t - last_t;
        last_t = t;
        if (win_idx >= win_len) begin
          avg_period = 32'(acc / ((win_len == 0) ? 1 : win_len));
          win_idx = 1;
          acc = period;
          win_len = window_count(period);
        end else begin
          win_idx++;
          acc += period;
        end
        return;
      end
      since = (t < last_t) ? 32'd0 : t - last_t;
      if (avg_period == 0) begin
        freq = '1;
      end else begin
        q = 64'd10000000000 / avg_period;
        freq = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
      end
      thr = timeout_us;
      if (zero_hold) thr = (margin_us > thr) ? 32'd0 : thr - margin_us;
      if (period > thr || since > thr) begin
        freq = 0;
        zero_hold = 1;
      end else begin
        zero_hold = 0;
      end
      pp = (ppr == 0) ? 1 : ppr;
      rpm = ((freq / pp) * 60) / 10000;
      hist_total = hist_total - rpm_hist[slot] + 32'(rpm);
      rpm_hist[slot] = 32'(rpm);
      slot = (slot + 1 >= SMOOTH_DEPTH) ? 0 : slot + 1;
      readouts.push_back({7'd0, 4'(win_len), period,
                          25'(hist_total / SMOOTH_DEPTH), 25'(rpm),
                          19'(freq / 10000), freq});
    endfunction

    function void check_result(bit [143:0] got);
      int lsb[6] = '{0, 32, 51, 76, 101, 133};
      int wid[6] = '{32, 19, 25, 25, 32, 4};
      string nm[6] = '{"freq_scaled", "freq_hz", "rpm", "rpm_smoothed",
                       "last_period_us", "readings_in_use"};
      bit [143:0] want, fe, fg;
      bit bad;
      if (readouts.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transaction %h", got);
        return;
      end
      want = readouts.pop_front();
      bad = 0;
      for (int i = 0; i < 6; i++) begin
        fe = (want >> lsb[i]) & ((144'd1 << wid[i]) - 1);
        fg = (got >> lsb[i]) & ((144'd1 << wid[i]) - 1);
        if (fe != fg) begin
          if (!bad) errors++;
          if (errors <= 10)
            $display("mismatch %s: expected %0d actual %0d", nm[i], fe, fg);
          bad = 1;
        end
      end
      if (!bad && got[143:137] != 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: pad bits set %h", got[143:137]);
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [31:0]  in_tdata = 0;    // [31:0] time_us
  logic         in_tuser = 0;    // [0] req_type
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [143:0] out_tdata;       // [31:0] freq_scaled, [50:32] freq_hz,
                                 // [75:51] rpm, [100:76] rpm_smoothed,
                                 // [132:101] last_period_us,
                                 // [136:133] readings_in_use
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = 0;
  logic [31:0]  cfg_wdata = 0;

  tach_scoreboard sb = new();
  int cycles = 0;
  bit in_burst = 0, out_burst = 0;   // stretches with no idling
  bit [31:0] now_us = 0;

  pulse_tachometer_adaptive_average #(.SMOOTH_DEPTH(SMOOTH_DEPTH)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #4 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("pulse_tachometer_adaptive_average test failed");
      $finish;
    end
  end

  // Result side: random stalls; tready stays high across back-to-back
  // transactions when the drawn gap is zero.
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 40) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_tready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  // One input transaction; tvalid is left high so a zero gap stays
  // back-to-back.
  task automatic send(bit req, bit [31:0] t);
    int gap;
    if ($urandom_range(0, 40) == 0) in_burst = ~in_burst;
    gap = in_burst ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= req;
    in_tdata  <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(req, t);
  endtask

  // Drain: pulses leave nothing queued, so a settle pause follows.
  task automatic drain();
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.readouts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(bit [2:0] addr, bit [31:0] val);
    cfg_we    <= 1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(addr, val);
  endtask

  task automatic cfg_all(bit [7:0] p, bit [31:0] tmo, bit [15:0] mg,
                         bit [31:0] sl, bit [31:0] fs, bit [3:0] mx);
    cfg_write(ptaa_pkg::REG_PPR, 32'(p));
    cfg_write(ptaa_pkg::REG_TIMEOUT, tmo);
    cfg_write(ptaa_pkg::REG_MARGIN, 32'(mg));
    cfg_write(ptaa_pkg::REG_SLOW, sl);
    cfg_write(ptaa_pkg::REG_FAST, fs);
    cfg_write(ptaa_pkg::REG_MAXRD, 32'(mx));
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Mostly plausible pulse trains with readouts in between, plus noise.
  task automatic random_traffic(int n);
    bit [31:0] step;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 12) begin
        send(1'($urandom_range(0, 1)), $urandom);
      end else if ($urandom_range(0, 3) == 0) begin
        send(ptaa_pkg::REQ_READOUT, now_us + $urandom_range(0, 30000));
      end else begin
        case ($urandom_range(0, 9))
          0:       step = $urandom_range(0, 200);
          1:       step = $urandom;
          default: step = $urandom_range(1000, 60000);
        endcase
        now_us += step;
        send(ptaa_pkg::REQ_PULSE, now_us);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reset defaults, timeout reading, zero and tiny averages,
    // timestamp wrap, readout time before the last pulse
    send(ptaa_pkg::REQ_READOUT, 32'd0);
    send(ptaa_pkg::REQ_PULSE, 32'd1000);
    send(ptaa_pkg::REQ_PULSE, 32'd1000);
    send(ptaa_pkg::REQ_PULSE, 32'd1000);
    send(ptaa_pkg::REQ_READOUT, 32'd1000);
    send(ptaa_pkg::REQ_PULSE, 32'd1001);
    send(ptaa_pkg::REQ_PULSE, 32'd1002);
    send(ptaa_pkg::REQ_PULSE, 32'd1003);
    send(ptaa_pkg::REQ_READOUT, 32'd1003);
    send(ptaa_pkg::REQ_PULSE, 32'hFFFF_FFF0);
    send(ptaa_pkg::REQ_PULSE, 32'h0000_0010);
    send(ptaa_pkg::REQ_READOUT, 32'd5);
    send(ptaa_pkg::REQ_READOUT, 32'hFFFF_FFFF);
    now_us = 32'd100;
    for (int i = 0; i < 6; i++) begin
      now_us += 32'd20000;
      send(ptaa_pkg::REQ_PULSE, now_us);
      send(ptaa_pkg::REQ_READOUT, now_us + 32'd10);
    end
    drain();
    // writes beyond the register list must be ignored
    cfg_write(3'd6, '1);
    cfg_write(3'd7, 32'd1);
    cfg_we <= 0;
    @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: cfg_all(ptaa_pkg::PPR_RST, ptaa_pkg::TIMEOUT_RST, ptaa_pkg::MARGIN_RST,
                   ptaa_pkg::SLOW_RST, ptaa_pkg::FAST_RST, ptaa_pkg::MAXRD_RST);
        1: cfg_all(8'd255, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                   4'd15);
        2: cfg_all(8'd1, 32'd3000, 16'd0, 32'd1, 32'd0, 4'd1);
        // zero ppr, margin above timeout, equal periods, zero max count
        3: cfg_all(8'd0, 32'd3000, 16'hFFFF, 32'd8000, 32'd8000, 4'd0);
        default:
          cfg_all(8'($urandom_range(1, 255)), $urandom_range(3000, 200000),
                  16'($urandom_range(0, 65535)), $urandom_range(10000, 80000),
                  $urandom_range(0, 9999), 4'($urandom_range(1, 15)));
      endcase
      random_traffic(PHASE_ITEMS);
    end

    drain();
    if (sb.errors == 0 && sb.readouts.size() == 0) begin
      $display("pulse_tachometer_adaptive_average test passed");
    end else begin
      $display("pulse_tachometer_adaptive_average test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
